FILE: design/cddo_pkg.sv
// Shared package for the calendar date offset pipeline.
// Holds field widths, calendar constants, reciprocal multipliers and stage payload types.
// No dependencies.
package cddo_pkg;

  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int OFF_W    = 23;
  localparam int SERIAL_W = 22;
  localparam int DOY_W    = 9;

  localparam int MAX_YEAR = 9999;
  localparam int LAST_DAY = 365 * MAX_YEAR + MAX_YEAR / 4 - MAX_YEAR / 100 + MAX_YEAR / 400;

  localparam int DAYS_400 = 146097;
  localparam int DAYS_100 = 36524;
  localparam int DAYS_4   = 1461;
  localparam int DAYS_1   = 365;
  localparam int CENTURY  = 100;
  localparam int QUAD_C   = 400;
  localparam int LEAP_CYC = 4;
  localparam int LAST_Q4  = DAYS_100 / DAYS_4;

  localparam int DBY_W   = 23;
  localparam int MPART_W = 9;
  localparam int SUM_W   = 25;
  localparam int QY_W    = 8;
  localparam int N1_W    = 18;
  localparam int N2_W    = 16;
  localparam int N3_W    = 11;
  localparam int Q400_W  = 5;
  localparam int Q100_W  = 2;
  localparam int Q4_W    = 5;
  localparam int Q1_W    = 2;

  // Division by a constant is a multiply by a rounded-up reciprocal and a shift.
  localparam int SH_C100 = 21;
  localparam int KW_C100 = 15;
  localparam longint unsigned K_C100 = ((64'd1 << SH_C100) + CENTURY - 1) / CENTURY;
  localparam int SH_400 = 40;
  localparam int KW_400 = 23;
  localparam longint unsigned K_400 = ((64'd1 << SH_400) + DAYS_400 - 1) / DAYS_400;
  localparam int SH_100 = 34;
  localparam int KW_100 = 19;
  localparam longint unsigned K_100 = ((64'd1 << SH_100) + DAYS_100 - 1) / DAYS_100;
  localparam int SH_4 = 26;
  localparam int KW_4 = 16;
  localparam longint unsigned K_4 = ((64'd1 << SH_4) + DAYS_4 - 1) / DAYS_4;
  localparam int SH_1 = 20;
  localparam int KW_1 = 12;
  localparam longint unsigned K_1 = ((64'd1 << SH_1) + DAYS_1 - 1) / DAYS_1;

  localparam logic [MPART_W-1:0] DBM [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic [SERIAL_W-1:0] serial;
    logic [SERIAL_W-1:0] rem;
    logic                sat;
  } fwd_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] rem;
    logic [Q400_W-1:0]   q400;
    logic [Q100_W-1:0]   q100;
    logic [Q4_W-1:0]     q4;
    logic [Q1_W-1:0]     q1;
    logic [SERIAL_W-1:0] serial;
    logic                sat;
  } spl_t;

  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [SERIAL_W-1:0] serial;
    logic [DOY_W-1:0]    doy;
    logic                leap;
    logic                sat;
  } res_t;

endpackage

FILE: design/cddo_fwd.sv
// Four-stage date to serial day pipeline: clamps the date, adds the offset and saturates.
// Depends on cddo_pkg.
module cddo_fwd (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  logic [cddo_pkg::YEAR_W-1:0]    up_year,
  input  logic [cddo_pkg::MONTH_W-1:0]   up_month,
  input  logic [cddo_pkg::DAY_W-1:0]     up_day,
  input  logic signed [cddo_pkg::OFF_W-1:0] up_offset,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output cddo_pkg::fwd_t                 dn_data
);
  import cddo_pkg::*;

  localparam int NSTG = 4;
  localparam int PC_W = YEAR_W + KW_C100;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] ld;

  logic [YEAR_W-1:0]  y_c;
  logic [YEAR_W-1:0]  p_c;
  logic [MONTH_W-1:0] m_c;
  logic [PC_W-1:0]    prod_p;
  logic [PC_W-1:0]    prod_y;

  logic [YEAR_W-1:0]       p_r;
  logic [YEAR_W-1:0]       y_r;
  logic [MONTH_W-1:0]      m_r;
  logic [DAY_W-1:0]        d_r;
  logic signed [OFF_W-1:0] off1_r;
  logic [QY_W-1:0]         q100p_r;
  logic [QY_W-1:0]         q100y_r;

  logic [DBY_W-1:0]   dby_nxt;
  logic [MPART_W-1:0] mpart_nxt;
  logic               r100zero;
  logic               leap_c;

  logic [DBY_W-1:0]        dby_r;
  logic [MPART_W-1:0]      mpart_r;
  logic signed [OFF_W-1:0] off2_r;

  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [SUM_W-1:0] sum_r;

  fwd_t out_nxt;
  fwd_t out_r;

  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || dn_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[NSTG-1];
  assign dn_data  = out_r;

  always_comb begin
    y_c = (up_year == '0) ? YEAR_W'(1) : up_year;
    if (up_month == '0) begin
      m_c = MONTH_W'(1);
    end else if (up_month > MONTH_W'(13)) begin
      m_c = MONTH_W'(13);
    end else begin
      m_c = up_month;
    end
    p_c    = y_c - YEAR_W'(1);
    prod_p = PC_W'(p_c) * PC_W'(K_C100);
    prod_y = PC_W'(y_c) * PC_W'(K_C100);
  end

  always_comb begin
    dby_nxt = DBY_W'(p_r) * DBY_W'(DAYS_1) + DBY_W'(p_r >> 2) - DBY_W'(q100p_r)
            + DBY_W'(q100p_r >> 2);
    r100zero = (y_r == YEAR_W'(q100y_r) * YEAR_W'(CENTURY));
    leap_c   = (y_r[1:0] == 2'b00 && !r100zero) || (r100zero && q100y_r[1:0] == 2'b00);
    mpart_nxt = DBM[m_r - MONTH_W'(1)] + MPART_W'((m_r > MONTH_W'(2)) && leap_c)
              + MPART_W'(d_r);
  end

  assign sum_nxt = $signed({{(SUM_W - DBY_W){1'b0}}, dby_r})
                 + $signed({{(SUM_W - MPART_W){1'b0}}, mpart_r})
                 + SUM_W'(off2_r);

  always_comb begin
    if (sum_r < $signed(SUM_W'(1))) begin
      out_nxt.serial = SERIAL_W'(1);
      out_nxt.rem    = '0;
      out_nxt.sat    = 1'b1;
    end else if (sum_r > $signed(SUM_W'(LAST_DAY))) begin
      out_nxt.serial = SERIAL_W'(LAST_DAY);
      out_nxt.rem    = SERIAL_W'(LAST_DAY - 1);
      out_nxt.sat    = 1'b1;
    end else begin
      out_nxt.serial = sum_r[SERIAL_W-1:0];
      out_nxt.rem    = sum_r[SERIAL_W-1:0] - SERIAL_W'(1);
      out_nxt.sat    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p_r     <= p_c;
      y_r     <= y_c;
      m_r     <= m_c;
      d_r     <= up_day;
      off1_r  <= up_offset;
      q100p_r <= prod_p[SH_C100 +: QY_W];
      q100y_r <= prod_y[SH_C100 +: QY_W];
    end
    if (ld[1]) begin
      dby_r   <= dby_nxt;
      mpart_r <= mpart_nxt;
      off2_r  <= off1_r;
    end
    if (ld[2]) begin
      sum_r <= sum_nxt;
    end
    if (ld[3]) begin
      out_r <= out_nxt;
    end
  end

endmodule

FILE: design/cddo_split.sv
// Seven-stage split of a zero-based day count into 400, 100, 4 and 1 year cycles.
// Depends on cddo_pkg.
module cddo_split (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  cddo_pkg::fwd_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cddo_pkg::spl_t dn_data
);
  import cddo_pkg::*;

  localparam int NSTG  = 7;
  localparam int P4H_W = SERIAL_W + KW_400;
  localparam int P1H_W = N1_W + KW_100;
  localparam int P4_W  = N2_W + KW_4;
  localparam int P1_W  = N3_W + KW_1;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] ld;
  spl_t            st_r   [NSTG];
  spl_t            st_nxt [NSTG];

  logic [P4H_W-1:0] prod400;
  logic [P1H_W-1:0] prod100;
  logic [P4_W-1:0]  prod4;
  logic [P1_W-1:0]  prod1;
  logic [2:0]       q100_raw;
  logic [2:0]       q1_raw;

  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || dn_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[NSTG-1];
  assign dn_data  = st_r[NSTG-1];

  always_comb begin
    prod400  = P4H_W'(up_data.rem) * P4H_W'(K_400);
    prod100  = P1H_W'(st_r[1].rem[N1_W-1:0]) * P1H_W'(K_100);
    prod4    = P4_W'(st_r[3].rem[N2_W-1:0]) * P4_W'(K_4);
    prod1    = P1_W'(st_r[5].rem[N3_W-1:0]) * P1_W'(K_1);
    q100_raw = prod100[SH_100 +: 3];
    q1_raw   = prod1[SH_1 +: 3];

    st_nxt[0]        = '0;
    st_nxt[0].rem    = up_data.rem;
    st_nxt[0].serial = up_data.serial;
    st_nxt[0].sat    = up_data.sat;
    st_nxt[0].q400   = prod400[SH_400 +: Q400_W];

    st_nxt[1]     = st_r[0];
    st_nxt[1].rem = st_r[0].rem - SERIAL_W'(st_r[0].q400) * SERIAL_W'(DAYS_400);

    st_nxt[2]      = st_r[1];
    st_nxt[2].q100 = (q100_raw > 3'd3) ? Q100_W'(3) : q100_raw[Q100_W-1:0];

    st_nxt[3]     = st_r[2];
    st_nxt[3].rem = st_r[2].rem - SERIAL_W'(st_r[2].q100) * SERIAL_W'(DAYS_100);

    st_nxt[4]    = st_r[3];
    st_nxt[4].q4 = prod4[SH_4 +: Q4_W];

    st_nxt[5]     = st_r[4];
    st_nxt[5].rem = st_r[4].rem - SERIAL_W'(st_r[4].q4) * SERIAL_W'(DAYS_4);

    st_nxt[6]    = st_r[5];
    st_nxt[6].q1 = (q1_raw > 3'd3) ? Q1_W'(3) : q1_raw[Q1_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (ld[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (ld[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

endmodule

FILE: design/cddo_month.sv
// Two-stage year assembly and month lookup that forms the output register.
// Depends on cddo_pkg.
module cddo_month (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  cddo_pkg::spl_t up_data,
  output logic           dn_valid,
  input  logic           dn_ready,
  output cddo_pkg::res_t dn_data
);
  import cddo_pkg::*;

  localparam int NSTG = 2;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] ld;

  res_t y_nxt;
  res_t y_r;
  res_t m_nxt;
  res_t m_r;

  logic [MPART_W-1:0] start;
  logic [MONTH_W-1:0] mo;

  always_comb begin
    ld[NSTG-1] = !v_r[NSTG-1] || dn_ready;
    ld[0]      = !v_r[0] || ld[1];
  end

  assign up_ready = ld[0];
  assign dn_valid = v_r[NSTG-1];
  assign dn_data  = m_r;

  always_comb begin
    y_nxt        = '0;
    y_nxt.serial = up_data.serial;
    y_nxt.sat    = up_data.sat;
    y_nxt.doy    = DOY_W'(up_data.rem - SERIAL_W'(up_data.q1) * SERIAL_W'(DAYS_1));
    y_nxt.year   = YEAR_W'(up_data.q400) * YEAR_W'(QUAD_C)
                 + YEAR_W'(up_data.q100) * YEAR_W'(CENTURY)
                 + YEAR_W'(up_data.q4) * YEAR_W'(LEAP_CYC)
                 + YEAR_W'(up_data.q1) + YEAR_W'(1);
    y_nxt.leap   = (up_data.q1 == Q1_W'(3))
                && (up_data.q4 != Q4_W'(LAST_Q4) || up_data.q100 == Q100_W'(3));
  end

  always_comb begin
    mo    = MONTH_W'(12);
    start = DBM[11] + MPART_W'(y_r.leap);
    for (int i = 11; i >= 0; i--) begin
      if (y_r.doy < DBM[i+1] + MPART_W'(y_r.leap && (i >= 1))) begin
        mo    = MONTH_W'(i + 1);
        start = DBM[i] + MPART_W'(y_r.leap && (i >= 2));
      end
    end
    m_nxt       = y_r;
    m_nxt.month = mo;
    m_nxt.day   = DAY_W'(y_r.doy - start + MPART_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ld[0]) begin
        v_r[0] <= up_valid;
      end
      if (ld[1]) begin
        v_r[1] <= v_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      y_r <= y_nxt;
    end
    if (ld[1]) begin
      m_r <= m_nxt;
    end
  end

endmodule

FILE: design/calendar_date_day_offset.sv
// Top level of the calendar date offset pipeline: adds a signed day count to a date.
// Depends on cddo_pkg, cddo_fwd, cddo_split and cddo_month.
//
// The input channel takes a Gregorian date and a signed day offset in one transfer.
// The result channel returns the shifted date, its serial day number (0001-01-01 is
// day 1), the zero-based day within the year, the leap flag and a saturation flag.
// A sum below day 1 or past the last day of the final year is clamped to that bound.
// Both channels use valid and ready; a transfer happens when both are high.
// The datapath is a 13-stage pipeline: four stages build and clamp the serial
// number, seven split it into year cycles with reciprocal multipliers, and two
// assemble the year and look up the month. One transfer per cycle is sustained in
// both directions while out_ready stays high. When the receiver stalls, each stage
// holds its item and empty stages still fill, so input transfers continue until every
// stage holds an item. Synchronous reset empties the pipeline; no item survives it.
module calendar_date_day_offset (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [cddo_pkg::YEAR_W-1:0]        in_year,
  input  logic [cddo_pkg::MONTH_W-1:0]       in_month,
  input  logic [cddo_pkg::DAY_W-1:0]         in_day,
  input  logic signed [cddo_pkg::OFF_W-1:0]  in_day_offset,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cddo_pkg::YEAR_W-1:0]        out_year,
  output logic [cddo_pkg::MONTH_W-1:0]       out_month,
  output logic [cddo_pkg::DAY_W-1:0]         out_day,
  output logic [cddo_pkg::SERIAL_W-1:0]      out_serial_day,
  output logic [cddo_pkg::DOY_W-1:0]         out_day_in_year,
  output logic                               out_leap_year,
  output logic                               out_out_of_range
);
  import cddo_pkg::*;

  logic fwd_valid;
  logic fwd_ready;
  fwd_t fwd_data;
  logic spl_valid;
  logic spl_ready;
  spl_t spl_data;
  res_t res;

  cddo_fwd u_fwd (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (in_valid),
    .up_ready  (in_ready),
    .up_year   (in_year),
    .up_month  (in_month),
    .up_day    (in_day),
    .up_offset (in_day_offset),
    .dn_valid  (fwd_valid),
    .dn_ready  (fwd_ready),
    .dn_data   (fwd_data)
  );

  cddo_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (fwd_valid),
    .up_ready (fwd_ready),
    .up_data  (fwd_data),
    .dn_valid (spl_valid),
    .dn_ready (spl_ready),
    .dn_data  (spl_data)
  );

  cddo_month u_month (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (spl_valid),
    .up_ready (spl_ready),
    .up_data  (spl_data),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign out_year         = res.year;
  assign out_month        = res.month;
  assign out_day          = res.day;
  assign out_serial_day   = res.serial;
  assign out_day_in_year  = res.doy;
  assign out_leap_year    = res.leap;
  assign out_out_of_range = res.sat;

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_serial_day == SERIAL_W'(1) || out_serial_day == SERIAL_W'(LAST_DAY)))
    else $error("Saturated result is not at a range bound.");

  a_serial_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_serial_day >= SERIAL_W'(1) && out_serial_day <= SERIAL_W'(LAST_DAY)))
    else $error("Serial day number is outside the supported range.");

  a_doy_leap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_leap_year) |-> (out_day_in_year <= DOY_W'(DAYS_1 - 1)))
    else $error("Day of year exceeds the length of a common year.");

  a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= MONTH_W'(1) && out_month <= MONTH_W'(12)
                   && out_day >= DAY_W'(1)))
    else $error("Month or day of the result is out of range.");

endmodule
